// ===== src/button_command_decoder_unit_defines.svh =====
// assertion macros used by the decoder rtl
`ifndef BUTTON_COMMAND_DECODER_UNIT_DEFINES_SVH
`define BUTTON_COMMAND_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define BCD_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, checked outside reset
`define BCD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BCD_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define BCD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/bcd_pkg.sv =====
package bcd_pkg;

   // command codes
   localparam logic [2:0] CMD_NONE       = 3'd0;
   localparam logic [2:0] CMD_NEXT       = 3'd1;
   localparam logic [2:0] CMD_PREV       = 3'd2;
   localparam logic [2:0] CMD_SEEK_FWD   = 3'd3;
   localparam logic [2:0] CMD_SEEK_REV   = 3'd4;
   localparam logic [2:0] CMD_RESUME     = 3'd5;
   localparam logic [2:0] CMD_PLAY_PAUSE = 3'd6;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLUME_STEP  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLUME_LIMIT = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARTIST_COUNT = 2'd3;

   // reset values
   localparam logic [15:0] RST_LONG_PRESS   = 16'd500;
   localparam logic [7:0]  RST_VOLUME_STEP  = 8'd10;
   localparam logic [7:0]  RST_VOLUME_LIMIT = 8'd100;
   localparam logic [15:0] RST_ARTIST_COUNT = 16'd1;
   localparam logic [7:0]  RST_VOLUME       = 8'd20;

   // single-button masks
   localparam logic [7:0] BTN_NEXT       = 8'h01;
   localparam logic [7:0] BTN_PLAY_PAUSE = 8'h02;
   localparam logic [7:0] BTN_PREV       = 8'h04;
   localparam logic [7:0] BTN_VOL_UP     = 8'h08;
   localparam logic [7:0] BTN_VOL_DOWN   = 8'h10;
   localparam logic [7:0] BTN_LED        = 8'h20;
   localparam logic [7:0] BTN_ARTIST_UP  = 8'h40;
   localparam logic [7:0] BTN_ARTIST_DN  = 8'h80;

   typedef struct packed {
      logic [7:0]  buttons;
      logic [31:0] now_ticks;
      logic        playing;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  command;
      logic        stop_first;
      logic        artist_changed;
      logic [15:0] artist_index;
      logic        volume_changed;
      logic [7:0]  volume;
      logic [7:0]  led_pattern;
   } rsp_payload_type;

endpackage

// ===== src/button_command_decoder_unit.sv =====
// button command decoder
// one request transfer is one poll of the eight-button port: button bits,
// the current tick count and the playing flag. each poll yields exactly one
// response transfer carrying the player command, artist and volume updates
// and the byte for the eight LEDs.
// the poll is captured in an input register, decoded against the held state
// by one level of logic and written to the response register. a poll thus
// passes the input register, then the response register, and a new poll can
// be taken every cycle while the receiver takes each response (one item per
// cycle sustained, set by the single register-to-register decode path).
// when the response receiver stalls, the response register holds, the input
// register fills, and req_ready drops until the response is taken; nothing
// is lost or repeated.
// the csr port is a plain write port (enable, index, 16-bit data); the user
// must write it only while no poll is in flight, the block does not enforce it.
// synchronous active-high reset empties both stages, restores the register
// defaults (long press 500, step 10, limit 100, one artist) and the state
// (volume 20, LEDs enabled, artist 0, phase 0).
`include "button_command_decoder_unit_defines.svh"

module button_command_decoder_unit
   import bcd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_data,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // configuration registers
   logic [15:0] long_press_ff;
   logic [7:0]  volume_step_ff;
   logic [7:0]  volume_limit_ff;
   logic [15:0] artist_count_ff;

   // decoder state
   logic [7:0]  prev_buttons_ff, prev_buttons_in;
   logic [31:0] press_start_ff, press_start_in;
   logic        seek_sent_ff, seek_sent_in;
   logic [7:0]  volume_ff, volume_in;
   logic        leds_enabled_ff, leds_enabled_in;
   logic [15:0] artist_ff, artist_in;
   logic [3:0]  poll_phase_ff;

   // pipeline
   logic            in_valid_ff;
   req_payload_type in_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic            advance;

   // decode intermediates
   logic [7:0]  cur_b;
   logic [7:0]  prv_b;
   logic [31:0] elapsed;
   logic [31:0] long_ext;
   logic        elapsed_above;
   logic        elapsed_below;
   logic [8:0]  vol_sum;
   logic [7:0]  vol_up;
   logic [7:0]  vol_down;
   logic        artist_next_ok;
   logic        chaser_on;
   logic [2:0]  phase_low;

   // decode stage moves when the response register is free or being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= RST_LONG_PRESS;
         volume_step_ff  <= RST_VOLUME_STEP;
         volume_limit_ff <= RST_VOLUME_LIMIT;
         artist_count_ff <= RST_ARTIST_COUNT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LONG_PRESS:   long_press_ff   <= csr_write_data;
            CSR_VOLUME_STEP:  volume_step_ff  <= csr_write_data[7:0];
            CSR_VOLUME_LIMIT: volume_limit_ff <= csr_write_data[7:0];
            CSR_ARTIST_COUNT: artist_count_ff <= csr_write_data;
         endcase
      end
   end

   // shared arithmetic for the decode
   assign cur_b         = in_ff.buttons;
   assign prv_b         = prev_buttons_ff;
   assign elapsed       = in_ff.now_ticks - press_start_ff;  // wraps modulo 2^32
   assign long_ext      = {16'd0, long_press_ff};
   assign elapsed_above = elapsed > long_ext;
   assign elapsed_below = elapsed < long_ext;
   // volume up sums without wrap, then clamps to the limit
   assign vol_sum  = {1'b0, volume_ff} + {1'b0, volume_step_ff};
   assign vol_up   = (vol_sum > {1'b0, volume_limit_ff}) ? volume_limit_ff : vol_sum[7:0];
   assign vol_down = (volume_ff > volume_step_ff) ? (volume_ff - volume_step_ff) : 8'd0;
   // an artist count of zero never allows a step up
   assign artist_next_ok = ({1'b0, artist_ff} + 17'd1) < {1'b0, artist_count_ff};
   // chaser only while idle: no button now or in the last poll
   assign chaser_on = leds_enabled_ff && in_ff.playing && (prv_b == 8'd0) && (cur_b == 8'd0);
   assign phase_low = poll_phase_ff[2:0];

   always_comb begin
      prev_buttons_in = cur_b;
      press_start_in  = press_start_ff;
      seek_sent_in    = seek_sent_ff;
      volume_in       = volume_ff;
      leds_enabled_in = leds_enabled_ff;
      artist_in       = artist_ff;

      rsp_in.command        = CMD_NONE;
      rsp_in.stop_first     = 1'b0;
      rsp_in.artist_changed = 1'b0;
      rsp_in.volume_changed = 1'b0;

      // next button and play/pause
      if (cur_b == BTN_NEXT && prv_b == 8'd0) begin
         press_start_in = in_ff.now_ticks;
      end else if (cur_b == BTN_NEXT && !seek_sent_ff) begin
         // long hold sends one seek per press
         if (elapsed_above) begin
            rsp_in.command = CMD_SEEK_FWD;
            seek_sent_in   = 1'b1;
         end
      end else if (prv_b == BTN_NEXT && cur_b == 8'd0) begin
         // release: short press steps, long press resumes
         rsp_in.command = elapsed_below ? CMD_NEXT : CMD_RESUME;
         seek_sent_in   = 1'b0;
      end else if (cur_b == BTN_PLAY_PAUSE && prv_b == 8'd0) begin
         rsp_in.command = CMD_PLAY_PAUSE;
      end

      // previous button, volume, LEDs and artist
      if (cur_b == BTN_PREV && prv_b == 8'd0) begin
         press_start_in = in_ff.now_ticks;
      end else if (cur_b == BTN_PREV && !seek_sent_ff) begin
         if (elapsed_above) begin
            rsp_in.command = CMD_SEEK_REV;
            seek_sent_in   = 1'b1;
         end
      end else if (prv_b == BTN_PREV && cur_b == 8'd0) begin
         rsp_in.command = elapsed_below ? CMD_PREV : CMD_RESUME;
         seek_sent_in   = 1'b0;
      end else if (cur_b == BTN_VOL_UP && prv_b == 8'd0) begin
         volume_in             = vol_up;
         rsp_in.volume_changed = 1'b1;
      end else if (cur_b == BTN_VOL_DOWN && prv_b == 8'd0) begin
         volume_in             = vol_down;
         rsp_in.volume_changed = 1'b1;
      end else if (prv_b == BTN_LED && cur_b == 8'd0) begin
         leds_enabled_in = !leds_enabled_ff;
      end else if (cur_b == BTN_ARTIST_UP && prv_b == 8'd0) begin
         if (artist_next_ok) begin
            rsp_in.stop_first     = in_ff.playing;
            artist_in             = artist_ff + 16'd1;
            rsp_in.artist_changed = 1'b1;
         end
      end else if (cur_b == BTN_ARTIST_DN && prv_b == 8'd0) begin
         if (artist_ff != 16'd0) begin
            rsp_in.stop_first     = in_ff.playing;
            artist_in             = artist_ff - 16'd1;
            rsp_in.artist_changed = 1'b1;
         end
      end

      rsp_in.artist_index = artist_in;
      rsp_in.volume       = volume_in;

      // bouncing chaser: phases 0..7 walk down from bit 7, 8..15 walk up from bit 0
      if (chaser_on) begin
         if (poll_phase_ff[3]) begin
            rsp_in.led_pattern = 8'd1 << phase_low;
         end else begin
            rsp_in.led_pattern = 8'd1 << (3'd7 - phase_low);
         end
      end else begin
         rsp_in.led_pattern = cur_b;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // state and response register update on each decoded poll
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         prev_buttons_ff <= 8'd0;
         press_start_ff  <= 32'd0;
         seek_sent_ff    <= 1'b0;
         volume_ff       <= RST_VOLUME;
         leds_enabled_ff <= 1'b1;
         artist_ff       <= 16'd0;
         poll_phase_ff   <= 4'd0;
      end else begin
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            prev_buttons_ff <= prev_buttons_in;
            press_start_ff  <= press_start_in;
            seek_sent_ff    <= seek_sent_in;
            volume_ff       <= volume_in;
            leds_enabled_ff <= leds_enabled_in;
            artist_ff       <= artist_in;
            poll_phase_ff   <= poll_phase_ff + 4'd1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // a decoded poll always lands in the response register
   `BCD_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff,
      "decoded poll did not reach the response register")
   // a held input stage must block new request transfers
   `BCD_ASSERT_IMPLY(a_full_blocks_req, clock, reset, in_valid_ff && !advance, !req_ready,
      "request accepted while input register is held")
   // a seek marks the press so it is not repeated
   `BCD_ASSERT_NEXT(a_seek_sets_flag, clock, reset,
      advance && (rsp_in.command == CMD_SEEK_FWD || rsp_in.command == CMD_SEEK_REV),
      seek_sent_ff, "seek sent without marking the press")
   // chaser drives exactly one LED
   `BCD_ASSERT_IMPLY(a_chaser_onehot, clock, reset, advance && chaser_on,
      $onehot(rsp_in.led_pattern), "chaser pattern not one-hot")
   // an artist step really moves the index
   `BCD_ASSERT_IMPLY(a_artist_moves, clock, reset, advance && rsp_in.artist_changed,
      artist_in != artist_ff, "artist change flagged without a new index")

endmodule

// ===== tb/button_command_decoder_unit_test.sv =====
`timescale 1ns / 100ps

module button_command_decoder_unit_test
   import bcd_pkg::*;
();

   // run ends here at the latest, far beyond the slowest correct run
   localparam int unsigned CYCLE_LIMIT = 200000;
   // random polls per settings phase
   localparam int unsigned PHASE_POLLS = 250;
   // receiver hold-off long enough to fill both stages and stall the sender
   localparam int unsigned LONG_HOLD_CYCLES = 120;

   // ---------------------------------------------------------------------
   // scoreboard: own copy of the decoder state and settings, predicts one
   // response per accepted poll and checks responses in order
   // ---------------------------------------------------------------------
   class decoder_scoreboard;
      logic [15:0] hold_ticks;
      logic [7:0]  vol_step;
      logic [7:0]  vol_limit;
      logic [15:0] artists;
      logic [7:0]  prior_buttons;
      logic [31:0] pressed_at;
      logic        seek_done;
      logic [7:0]  volume;
      logic        leds_on;
      logic [15:0] artist;
      logic [3:0]  chaser_phase;
      rsp_payload_type expected_responses[$];
      int unsigned failures;

      function new();
         hold_ticks    = RST_LONG_PRESS;
         vol_step      = RST_VOLUME_STEP;
         vol_limit     = RST_VOLUME_LIMIT;
         artists       = RST_ARTIST_COUNT;
         prior_buttons = 8'h00;
         pressed_at    = 32'h0;
         seek_done     = 1'b0;
         volume        = RST_VOLUME;
         leds_on       = 1'b1;
         artist        = 16'h0;
         chaser_phase  = 4'h0;
         failures      = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_LONG_PRESS:   hold_ticks = data;
            CSR_VOLUME_STEP:  vol_step   = data[7:0];
            CSR_VOLUME_LIMIT: vol_limit  = data[7:0];
            CSR_ARTIST_COUNT: artists    = data;
            default: ;
         endcase
      endfunction

      function void note_poll(req_payload_type poll);
         logic [7:0]  b;
         logic [7:0]  p;
         logic [31:0] elapsed;
         logic [31:0] limit_ticks;
         logic [8:0]  raised;
         rsp_payload_type r;
         b = poll.buttons;
         p = prior_buttons;
         elapsed = poll.now_ticks - pressed_at;
         limit_ticks = {16'h0000, hold_ticks};
         r = '0;
         r.command = CMD_NONE;

         // next button and play/pause
         if (b == BTN_NEXT && p == 8'h00) begin
            pressed_at = poll.now_ticks;
         end else if (b == BTN_NEXT && !seek_done) begin
            if (elapsed > limit_ticks) begin
               r.command = CMD_SEEK_FWD;
               seek_done = 1'b1;
            end
         end else if (p == BTN_NEXT && b == 8'h00) begin
            r.command = (elapsed < limit_ticks) ? CMD_NEXT : CMD_RESUME;
            seek_done = 1'b0;
         end else if (b == BTN_PLAY_PAUSE && p == 8'h00) begin
            r.command = CMD_PLAY_PAUSE;
         end

         // prev button, volume, leds, artist
         if (b == BTN_PREV && p == 8'h00) begin
            pressed_at = poll.now_ticks;
         end else if (b == BTN_PREV && !seek_done) begin
            if (elapsed > limit_ticks) begin
               r.command = CMD_SEEK_REV;
               seek_done = 1'b1;
            end
         end else if (p == BTN_PREV && b == 8'h00) begin
            r.command = (elapsed < limit_ticks) ? CMD_PREV : CMD_RESUME;
            seek_done = 1'b0;
         end else if (b == BTN_VOL_UP && p == 8'h00) begin
            raised = {1'b0, volume} + {1'b0, vol_step};
            volume = (raised > {1'b0, vol_limit}) ? vol_limit : raised[7:0];
            r.volume_changed = 1'b1;
         end else if (b == BTN_VOL_DOWN && p == 8'h00) begin
            volume = (volume > vol_step) ? volume - vol_step : 8'h00;
            r.volume_changed = 1'b1;
         end else if (p == BTN_LED && b == 8'h00) begin
            leds_on = ~leds_on;
         end else if (b == BTN_ARTIST_UP && p == 8'h00) begin
            if ({1'b0, artist} + 17'd1 < {1'b0, artists}) begin
               r.stop_first = poll.playing;
               artist = artist + 16'd1;
               r.artist_changed = 1'b1;
            end
         end else if (b == BTN_ARTIST_DN && p == 8'h00) begin
            if (artist != 16'h0) begin
               r.stop_first = poll.playing;
               artist = artist - 16'd1;
               r.artist_changed = 1'b1;
            end
         end

         // bouncing chaser only when idle now and in the last poll
         r.led_pattern = b;
         if (leds_on && poll.playing && p == 8'h00 && b == 8'h00) begin
            r.led_pattern = chaser_phase[3] ? (8'h01 << chaser_phase[2:0])
                                            : (8'h80 >> chaser_phase[2:0]);
         end

         chaser_phase = chaser_phase + 4'd1;
         prior_buttons = b;
         r.artist_index = artist;
         r.volume = volume;
         expected_responses.push_back(r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_responses.size() == 0) begin
            $error("response transfer with no poll outstanding");
            failures++;
            return;
         end
         want = expected_responses.pop_front();
         compare_field("command", 32'(want.command), 32'(got.command));
         compare_field("stop_first", 32'(want.stop_first), 32'(got.stop_first));
         compare_field("artist_changed", 32'(want.artist_changed),
                       32'(got.artist_changed));
         compare_field("artist_index", 32'(want.artist_index), 32'(got.artist_index));
         compare_field("volume_changed", 32'(want.volume_changed),
                       32'(got.volume_changed));
         compare_field("volume", 32'(want.volume), 32'(got.volume));
         compare_field("led_pattern", 32'(want.led_pattern), 32'(got.led_pattern));
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // block under test
   // ---------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_payload_type            req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_payload_type            rsp_data;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   button_command_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   decoder_scoreboard scoreboard = new();

   // idle percentages of both sides, changed per phase
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   // asks the response side for one long hold-off
   bit          long_hold_request;
   // long press setting in force, steers the hold times of gestures
   logic [15:0] current_hold;
   int unsigned polls_sent;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a run that hangs ends as a failure
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   // response side: checks every transfer, stalls at random, and holds off
   // for a long stretch on request so the block backs up into the sender
   initial begin : response_side
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            scoreboard.check_response(rsp_data);
         end
         if (long_hold_request) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   function automatic void set_idling(int unsigned sender_pct, int unsigned receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
   endfunction

   // offer one poll; valid stays high after the transfer so back-to-back
   // polls never drop it within a step
   task automatic send_poll(input req_payload_type poll);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= poll;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scoreboard.note_poll(poll);
      polls_sent++;
   endtask

   task automatic poll_buttons(input logic [7:0] buttons, input logic [31:0] ticks,
                               input logic playing);
      req_payload_type poll;
      poll.buttons = buttons;
      poll.now_ticks = ticks;
      poll.playing = playing;
      send_poll(poll);
   endtask

   // sender stops and waits until every predicted response has arrived
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (scoreboard.expected_responses.size() != 0) @(posedge clock);
   endtask

   // all four registers, one write per cycle; only while the block is idle
   task automatic write_settings(input logic [15:0] hold_ticks, input logic [7:0] step,
                                 input logic [7:0] limit, input logic [15:0] artists);
      logic [CSR_INDEX_WIDTH-1:0] reg_order [4];
      logic [CSR_DATA_WIDTH-1:0]  reg_value [4];
      reg_order = '{CSR_LONG_PRESS, CSR_VOLUME_STEP, CSR_VOLUME_LIMIT, CSR_ARTIST_COUNT};
      reg_value = '{hold_ticks, {8'h00, step}, {8'h00, limit}, artists};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= reg_order[i];
         csr_write_data <= reg_value[i];
         scoreboard.set_register(reg_order[i], reg_value[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      current_hold = hold_ticks;
   endtask

   // hold time around the long press setting: just below, exact, just above,
   // anywhere nearby, or anything at all (wraps included)
   function automatic logic [31:0] hold_offset();
      logic [31:0] lp;
      lp = {16'h0000, current_hold};
      case ($urandom_range(4))
         0: return lp - 32'd1;
         1: return lp;
         2: return lp + 32'd1;
         3: return $urandom_range(0, 2 * lp + 2);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic random_playing();
      return ($urandom_range(9) < 7);
   endfunction

   // one press-hold-release of a lone button, mostly next/prev, preceded by
   // a few idle polls that run the chaser; some noise and broken releases
   task automatic run_gesture();
      logic [7:0]  btn;
      logic [31:0] press_tick;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         repeat ($urandom_range(1, 3)) begin
            poll_buttons(8'($urandom_range(255)), $urandom(), 1'($urandom_range(1)));
         end
      end else begin
         pick = $urandom_range(9);
         if (pick < 3) begin
            btn = BTN_NEXT;
         end else if (pick < 6) begin
            btn = BTN_PREV;
         end else begin
            btn = 8'h01 << $urandom_range(7);
         end
         repeat ($urandom_range(0, 3)) poll_buttons(8'h00, $urandom(), random_playing());
         press_tick = $urandom();
         poll_buttons(btn, press_tick, random_playing());
         repeat ($urandom_range(0, 3)) begin
            poll_buttons(btn, press_tick + hold_offset(), random_playing());
         end
         if ($urandom_range(9) == 0) begin
            poll_buttons(8'($urandom_range(255)), press_tick + hold_offset(),
                         random_playing());
         end else begin
            poll_buttons(8'h00, press_tick + hold_offset(), random_playing());
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned phase_start;
      bit          hold_done;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_LONG_PRESS;
      csr_write_data <= '0;
      long_hold_request = 1'b0;
      polls_sent = 0;
      hold_done = 1'b0;
      current_hold = RST_LONG_PRESS;
      set_idling(23, 46);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part: defaults with three artists
      write_settings(RST_LONG_PRESS, RST_VOLUME_STEP, RST_VOLUME_LIMIT, 16'd3);
      poll_buttons(8'h00, 32'd0, 1'b1);                  // chaser, first phase
      poll_buttons(BTN_NEXT, 32'd1000, 1'b1);            // press
      poll_buttons(BTN_NEXT, 32'd1501, 1'b1);            // held past threshold: seek
      poll_buttons(BTN_NEXT, 32'd3000, 1'b1);            // seek only once per press
      poll_buttons(8'h00, 32'd3001, 1'b1);               // release after long: resume
      poll_buttons(BTN_NEXT, 32'd5000, 1'b0);
      poll_buttons(8'h00, 32'd5500, 1'b0);               // exactly threshold counts long
      poll_buttons(BTN_PREV, 32'hFFFF_FF00, 1'b1);       // press just before tick wrap
      poll_buttons(8'h00, 32'h0000_0010, 1'b1);          // short across the wrap: prev
      poll_buttons(BTN_PLAY_PAUSE, 32'd6000, 1'b1);
      poll_buttons(8'h00, 32'd6001, 1'b1);
      poll_buttons(BTN_VOL_UP, 32'd6002, 1'b1);
      poll_buttons(8'h00, 32'd6003, 1'b1);
      poll_buttons(BTN_VOL_DOWN, 32'd6004, 1'b1);
      poll_buttons(8'h00, 32'd6005, 1'b1);
      poll_buttons(BTN_LED, 32'd6006, 1'b1);
      poll_buttons(8'h00, 32'd6007, 1'b1);               // release toggles leds off
      poll_buttons(BTN_ARTIST_UP, 32'd6008, 1'b1);       // step while playing: stop first
      poll_buttons(8'h00, 32'd6009, 1'b1);
      poll_buttons(BTN_ARTIST_DN, 32'd6010, 1'b0);
      poll_buttons(8'h00, 32'd6011, 1'b0);
      poll_buttons(8'hFF, 32'hFFFF_FFFF, 1'b1);          // every button at once
      poll_buttons(8'h81, 32'd6012, 1'b0);
      poll_buttons(8'h00, 32'd6013, 1'b1);
      wait_for_responses();

      // random part: six settings, extremes first; idling changes every
      // second phase, the long receiver hold-off falls in a no-idle phase
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_settings(16'd0, 8'd0, 8'd0, 16'd0);
            1: write_settings(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
            2: write_settings(16'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                              8'($urandom_range(255)), 16'($urandom_range(1, 8)));
            3: write_settings(16'($urandom_range(65535)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 16'd1);
            4: write_settings(16'($urandom_range(1, 30)), 8'($urandom_range(1, 20)),
                              8'hFF, 16'hFFFF);
            default: write_settings(16'($urandom_range(200)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)), 16'($urandom_range(1, 20)));
         endcase
         if (phase < 2) begin
            set_idling(23, 46);
         end else if (phase < 4) begin
            set_idling(46, 23);
         end else begin
            set_idling(0, 0);
         end
         phase_start = polls_sent;
         while (polls_sent - phase_start < PHASE_POLLS) begin
            if (phase == 4 && !hold_done && polls_sent - phase_start > 60) begin
               long_hold_request = 1'b1;
               hold_done = 1'b1;
            end
            run_gesture();
         end
         wait_for_responses();
      end

      // settle past the two pipeline stages before the verdict
      repeat (10) @(posedge clock);
      if (scoreboard.failures == 0 && scoreboard.expected_responses.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/bcd_pkg.sv
src/button_command_decoder_unit.sv
tb/button_command_decoder_unit_test.sv
